// ===== design/texture_sampler_nearest_wrap_assert.svh =====
// Assertion macros for the texture sampler; they use clk_i and rst_ni of the including scope.
`ifndef TEXTURE_SAMPLER_NEAREST_WRAP_ASSERT_SVH
`define TEXTURE_SAMPLER_NEAREST_WRAP_ASSERT_SVH

// same-cycle implication
`define TSN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TSN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/tsn_pkg.sv =====
// Shared types and constants of the texture sampler.
package tsn_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned DIM_W     = 9;
  localparam int unsigned CH_W      = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned CQ_DEPTH  = 4;
  localparam int unsigned CQ_PTR_W  = 2;
  localparam int unsigned CQ_CNT_W  = 3;
  localparam int unsigned OQ_DEPTH  = 4;
  localparam int unsigned OQ_PTR_W  = 2;
  localparam int unsigned OQ_CNT_W  = 3;

  typedef enum logic {
    MODE_LOAD   = 1'b0,
    MODE_SAMPLE = 1'b1
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEX_WIDTH  = 2'd0,
    REG_TEX_HEIGHT = 2'd1
  } reg_idx_e;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } rgb_t;

  localparam rgb_t CYAN = '{r: 8'h00, g: 8'hFF, b: 8'hFF};

  typedef struct packed {
    logic              is_load;
    logic              cyan;
    logic [ADDR_W-1:0] addr;
    rgb_t              rgb;
  } cmd_t;

  typedef struct packed {
    logic                not_empty;
    logic [CQ_CNT_W-1:0] count;
  } cq_stat_t;

  typedef struct packed {
    logic s1_valid;
    logic s2_valid;
  } fr_stat_t;

  typedef struct packed {
    logic [OQ_CNT_W-1:0] count;
  } oq_stat_t;

endpackage

// ===== design/tsn_front.sv =====
// Front end: config registers, request intake, wrap and texel address computation.
module tsn_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tsn_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tsn_pkg::DIM_W-1:0]        cfg_data_i,
  input  logic                             push_i,
  output logic                             full_o,
  input  logic                             mode_i,
  input  logic [tsn_pkg::ADDR_W-1:0]       texel_index_i,
  input  logic [tsn_pkg::CH_W-1:0]         load_red_i,
  input  logic [tsn_pkg::CH_W-1:0]         load_green_i,
  input  logic [tsn_pkg::CH_W-1:0]         load_blue_i,
  input  logic signed [tsn_pkg::COORD_W-1:0] u_coord_i,
  input  logic signed [tsn_pkg::COORD_W-1:0] v_coord_i,
  input  tsn_pkg::cq_stat_t                cq_stat_i,
  output logic                             cmd_valid_o,
  output tsn_pkg::cmd_t                    cmd_o,
  output tsn_pkg::fr_stat_t                stat_o
);
  import tsn_pkg::*;

  logic [DIM_W-1:0] tex_width_q, tex_height_q;

  logic [FRAC_BITS-1:0]       fu, fv;
  logic [FRAC_BITS:0]         fv_inv;
  logic [DIM_W-1:0]           w_m1, h_m1;
  logic [FRAC_BITS+DIM_W-1:0] col_prod;
  logic [FRAC_BITS+DIM_W:0]   row_prod;
  logic [CQ_CNT_W-1:0]        credit;
  logic                       accept;

  logic                s1_valid_q, s1_load_q, s1_cyan_q;
  logic [ADDR_W-1:0]   s1_idx_q;
  rgb_t                s1_rgb_q;
  logic [DIM_W-1:0]    s1_col_q, s1_row_q;

  logic                s2_valid_q;
  cmd_t                s2_cmd_q, s2_cmd_d;
  logic [2*DIM_W-1:0]  addr_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_width_q  <= '0;
      tex_height_q <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_TEX_WIDTH:  tex_width_q  <= cfg_data_i;
        REG_TEX_HEIGHT: tex_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // queue entries plus everything still in the two stages
  assign credit = cq_stat_i.count + CQ_CNT_W'(s1_valid_q) + CQ_CNT_W'(s2_valid_q);
  assign full_o = credit >= CQ_CNT_W'(CQ_DEPTH);
  assign accept = push_i && !full_o;

  // fraction bits are the repeat wrap, negative values included
  assign fu     = u_coord_i[FRAC_BITS-1:0];
  assign fv     = v_coord_i[FRAC_BITS-1:0];
  assign fv_inv = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, fv};
  assign w_m1   = tex_width_q - DIM_W'(1);
  assign h_m1   = tex_height_q - DIM_W'(1);

  assign col_prod = (FRAC_BITS+DIM_W)'(fu) * (FRAC_BITS+DIM_W)'(w_m1);
  assign row_prod = (FRAC_BITS+DIM_W+1)'(fv_inv) * (FRAC_BITS+DIM_W+1)'(h_m1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_load_q <= (mode_e'(mode_i) == MODE_LOAD);
      s1_cyan_q <= (tex_width_q == '0) || (tex_height_q == '0);
      s1_idx_q  <= texel_index_i;
      s1_rgb_q  <= '{r: load_red_i, g: load_green_i, b: load_blue_i};
      s1_col_q  <= col_prod[FRAC_BITS+DIM_W-1:FRAC_BITS];
      s1_row_q  <= row_prod[FRAC_BITS+DIM_W-1:FRAC_BITS];
    end
  end

  // row*width+col, wrapped to the store size
  assign addr_sum = (2*DIM_W)'(s1_row_q) * (2*DIM_W)'(tex_width_q) + (2*DIM_W)'(s1_col_q);

  always_comb begin
    s2_cmd_d.is_load = s1_load_q;
    s2_cmd_d.cyan    = !s1_load_q && s1_cyan_q;
    s2_cmd_d.addr    = s1_load_q ? s1_idx_q : addr_sum[ADDR_W-1:0];
    s2_cmd_d.rgb     = s1_rgb_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_cmd_q <= s2_cmd_d;
    end
  end

  assign cmd_valid_o     = s2_valid_q;
  assign cmd_o           = s2_cmd_q;
  assign stat_o.s1_valid = s1_valid_q;
  assign stat_o.s2_valid = s2_valid_q;

endmodule

// ===== design/tsn_cmd_queue.sv =====
// Short command queue between the front end and the texel store.
module tsn_cmd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tsn_pkg::cmd_t     cmd_i,
  input  logic              pop_i,
  output tsn_pkg::cmd_t     cmd_o,
  output tsn_pkg::cq_stat_t stat_o
);
  import tsn_pkg::*;

  cmd_t                slot_q [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CQ_CNT_W-1:0] count_q, count_d;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) count_d = count_q + CQ_CNT_W'(1);
    if (pop_i && !push_i) count_d = count_q - CQ_CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + CQ_PTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + CQ_PTR_W'(1);
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= cmd_i;
  end

  assign cmd_o            = slot_q[rd_ptr_q];
  assign stat_o.count     = count_q;
  assign stat_o.not_empty = (count_q != '0);

endmodule

// ===== design/tsn_back.sv =====
// Back end: texel store, registered read and result queue.
module tsn_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tsn_pkg::cq_stat_t          cq_stat_i,
  input  tsn_pkg::cmd_t              cmd_i,
  output logic                       cq_pop_o,
  output logic                       empty_o,
  input  logic                       pop_i,
  output logic [tsn_pkg::CH_W-1:0]   red_o,
  output logic [tsn_pkg::CH_W-1:0]   green_o,
  output logic [tsn_pkg::CH_W-1:0]   blue_o,
  output tsn_pkg::oq_stat_t          stat_o
);
  import tsn_pkg::*;

  rgb_t                texel_mem [1 << ADDR_W];
  rgb_t                rd_data_q;
  logic                rd_valid_q, rd_cyan_q;

  rgb_t                oq_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] oq_wr_q, oq_rd_q;
  logic [OQ_CNT_W-1:0] oq_cnt_q, oq_cnt_d;
  logic                issue, rd_en, oq_push, oq_pop;

  // hold back while a read in flight could overfill the result queue
  assign issue    = cq_stat_i.not_empty &&
                    ((oq_cnt_q + OQ_CNT_W'(rd_valid_q)) < OQ_CNT_W'(OQ_DEPTH));
  assign cq_pop_o = issue;
  assign rd_en    = issue && !cmd_i.is_load;

  always_ff @(posedge clk_i) begin
    if (issue && cmd_i.is_load) texel_mem[cmd_i.addr] <= cmd_i.rgb;
    if (rd_en)                  rd_data_q <= texel_mem[cmd_i.addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_cyan_q <= cmd_i.cyan;
  end

  assign oq_push = rd_valid_q;
  assign oq_pop  = pop_i && !empty_o;

  always_comb begin
    oq_cnt_d = oq_cnt_q;
    if (oq_push && !oq_pop) oq_cnt_d = oq_cnt_q + OQ_CNT_W'(1);
    if (oq_pop && !oq_push) oq_cnt_d = oq_cnt_q - OQ_CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (oq_push) oq_wr_q <= oq_wr_q + OQ_PTR_W'(1);
      if (oq_pop)  oq_rd_q <= oq_rd_q + OQ_PTR_W'(1);
      oq_cnt_q <= oq_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_push) oq_q[oq_wr_q] <= rd_cyan_q ? CYAN : rd_data_q;
  end

  assign empty_o      = (oq_cnt_q == '0);
  assign red_o        = oq_q[oq_rd_q].r;
  assign green_o      = oq_q[oq_rd_q].g;
  assign blue_o       = oq_q[oq_rd_q].b;
  assign stat_o.count = oq_cnt_q;

endmodule

// ===== design/texture_sampler_nearest_wrap.sv =====
// Top level of the nearest-neighbour repeat-wrap texture sampler.
// Accepts one request per cycle while full is low: a load (mode 0) writes one RGB texel into a
// 64K x 24 texel RAM, a sample (mode 1) wraps u,v (Q15.16) to their fractions and returns
// the texel at floor(fu*(w-1)), floor((1-fv)*(h-1)), or cyan while width or height is zero.
// A sample result reaches the result ports through two multiplier stages (scale, then
// row*width+col), the command queue, the registered read of the single-port texel RAM
// and the result queue. Loads give no result.
// The RAM has no reset and no clearing pass; only loaded texels may be sampled. Write
// tex_width/tex_height only while the block is idle.
`include "texture_sampler_nearest_wrap_assert.svh"

module texture_sampler_nearest_wrap (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tsn_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tsn_pkg::DIM_W-1:0]          cfg_data_i,
  input  logic                               push,
  output logic                               full,
  input  logic                               mode_i,
  input  logic [tsn_pkg::ADDR_W-1:0]         texel_index_i,
  input  logic [tsn_pkg::CH_W-1:0]           load_red_i,
  input  logic [tsn_pkg::CH_W-1:0]           load_green_i,
  input  logic [tsn_pkg::CH_W-1:0]           load_blue_i,
  input  logic signed [tsn_pkg::COORD_W-1:0] u_coord_i,
  input  logic signed [tsn_pkg::COORD_W-1:0] v_coord_i,
  output logic                               empty,
  input  logic                               pop,
  output logic [tsn_pkg::CH_W-1:0]           red_o,
  output logic [tsn_pkg::CH_W-1:0]           green_o,
  output logic [tsn_pkg::CH_W-1:0]           blue_o
);
  import tsn_pkg::*;

  logic     cq_push, cq_pop;
  cmd_t     front_cmd, queue_cmd;
  cq_stat_t cq_stat;
  fr_stat_t fr_stat;
  oq_stat_t oq_stat;

  tsn_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .push_i        (push),
    .full_o        (full),
    .mode_i        (mode_i),
    .texel_index_i (texel_index_i),
    .load_red_i    (load_red_i),
    .load_green_i  (load_green_i),
    .load_blue_i   (load_blue_i),
    .u_coord_i     (u_coord_i),
    .v_coord_i     (v_coord_i),
    .cq_stat_i     (cq_stat),
    .cmd_valid_o   (cq_push),
    .cmd_o         (front_cmd),
    .stat_o        (fr_stat)
  );

  tsn_cmd_queue u_cmd_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cq_push),
    .cmd_i  (front_cmd),
    .pop_i  (cq_pop),
    .cmd_o  (queue_cmd),
    .stat_o (cq_stat)
  );

  tsn_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cq_stat_i (cq_stat),
    .cmd_i     (queue_cmd),
    .cq_pop_o  (cq_pop),
    .empty_o   (empty),
    .pop_i     (pop),
    .red_o     (red_o),
    .green_o   (green_o),
    .blue_o    (blue_o),
    .stat_o    (oq_stat)
  );

  `TSN_ASSERT_IMP(a_cq_no_overflow, cq_push, cq_stat.count < CQ_CNT_W'(CQ_DEPTH), "cq overflow")
  `TSN_ASSERT_IMP(a_cq_no_underflow, cq_pop, cq_stat.not_empty, "cq popped while empty")
  `TSN_ASSERT_IMP(a_oq_bound, 1'b1, oq_stat.count <= OQ_CNT_W'(OQ_DEPTH), "result queue overfilled")
  `TSN_ASSERT_NXT(a_accept_enters, push && !full, fr_stat.s1_valid, "accepted request lost")

endmodule

// ===== tb/sv/tb_texture_sampler_nearest_wrap.sv =====
// Self-checking testbench for the nearest-neighbour repeat-wrap texture sampler.
module tb_texture_sampler_nearest_wrap;
  import tsn_pkg::*;

  localparam int N_PHASES        = 10;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int DRAIN_GUARD     = 5000;
  localparam int SETTLE_CYCLES   = 12;
  localparam int MAX_PRINTED     = 30;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [CFG_IDX_W-1:0]      cfg_idx_i;
  logic [DIM_W-1:0]          cfg_data_i;
  logic                      push;
  logic                      full;
  logic                      mode_i;
  logic [ADDR_W-1:0]         texel_index_i;
  logic [CH_W-1:0]           load_red_i;
  logic [CH_W-1:0]           load_green_i;
  logic [CH_W-1:0]           load_blue_i;
  logic signed [COORD_W-1:0] u_coord_i;
  logic signed [COORD_W-1:0] v_coord_i;
  logic                      empty;
  logic                      pop;
  logic [CH_W-1:0]           red_o;
  logic [CH_W-1:0]           green_o;
  logic [CH_W-1:0]           blue_o;

  // shadow of the sampler: size registers and texel RAM with a written flag per entry
  logic [DIM_W-1:0] tex_w;
  logic [DIM_W-1:0] tex_h;
  rgb_t             texel_mem [0:65535];
  bit               texel_loaded [0:65535];
  rgb_t             texel_due_q [$];

  bit idle_on = 1'b1;
  int n_errors  = 0;
  int n_loads   = 0;
  int n_samples = 0;
  int n_cyan    = 0;
  int n_results = 0;
  int n_sizes   = 0;

  texture_sampler_nearest_wrap u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .push          (push),
    .full          (full),
    .mode_i        (mode_i),
    .texel_index_i (texel_index_i),
    .load_red_i    (load_red_i),
    .load_green_i  (load_green_i),
    .load_blue_i   (load_blue_i),
    .u_coord_i     (u_coord_i),
    .v_coord_i     (v_coord_i),
    .empty         (empty),
    .pop           (pop),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Timeout: %0d samples still pending", texel_due_q.size());
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(string msg);
    n_errors++;
    if (n_errors <= MAX_PRINTED) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // RAM address hit by a sample: keep the fraction bits, scale by size-1, floor
  function automatic logic [ADDR_W-1:0] texel_addr(logic [31:0] u, logic [31:0] v);
    longint unsigned fu, fv, col, row;
    fu  = 64'(u[FRAC_BITS-1:0]);
    fv  = 64'(v[FRAC_BITS-1:0]);
    col = (fu * (64'(tex_w) - 64'd1)) >> FRAC_BITS;
    row = (((64'd1 << FRAC_BITS) - fv) * (64'(tex_h) - 64'd1)) >> FRAC_BITS;
    return ADDR_W'(row * 64'(tex_w) + col);
  endfunction

  function automatic rgb_t rand_rgb();
    return rgb_t'(24'($urandom()));
  endfunction

  function automatic logic [31:0] rand_coord();
    logic [31:0] c;
    c = $urandom();
    case ($urandom_range(0, 7))
      0: c[15:0] = 16'h0000;
      1: c[15:0] = 16'hFFFF;
      2: c[15:0] = 16'($urandom_range(0, 3));
      3: c[15:0] = 16'($urandom_range(65532, 65535));
      4: c = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: ;
    endcase
    return c;
  endfunction

  // one request through push/full, then update the shadow at the accepting edge
  task automatic send_request(mode_e mode, logic [ADDR_W-1:0] idx, rgb_t px,
                              logic [31:0] u, logic [31:0] v);
    bit taken;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    push          <= 1'b1;
    mode_i        <= mode;
    texel_index_i <= idx;
    load_red_i    <= px.r;
    load_green_i  <= px.g;
    load_blue_i   <= px.b;
    u_coord_i     <= u;
    v_coord_i     <= v;
    do begin
      @(negedge clk_i);
      taken = !full;
      @(posedge clk_i);
    end while (!taken);
    if (mode == MODE_LOAD) begin
      texel_mem[idx]    = px;
      texel_loaded[idx] = 1'b1;
      n_loads++;
    end else begin
      n_samples++;
      if (tex_w == 0 || tex_h == 0) begin
        texel_due_q.push_back(CYAN);
        n_cyan++;
      end else begin
        texel_due_q.push_back(texel_mem[texel_addr(u, v)]);
      end
    end
  endtask

  // never sample an unwritten texel: load it first with random content
  task automatic sample_at(logic [31:0] u, logic [31:0] v);
    logic [ADDR_W-1:0] a;
    if (tex_w != 0 && tex_h != 0) begin
      a = texel_addr(u, v);
      if (!texel_loaded[a]) send_request(MODE_LOAD, a, rand_rgb(), $urandom(), $urandom());
    end
    send_request(MODE_SAMPLE, ADDR_W'($urandom()), rand_rgb(), u, v);
  endtask

  task automatic wait_idle();
    int guard;
    push  <= 1'b0;
    guard = 0;
    while (texel_due_q.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk_i);
      guard++;
    end
    if (texel_due_q.size() != 0) begin
      report_mismatch($sformatf("%0d sample results never arrived", texel_due_q.size()));
      texel_due_q.delete();
    end
    // loads may still be in flight with nothing left to wait for
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_texture_size(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_TEX_WIDTH;
    cfg_data_i <= w;
    @(posedge clk_i);
    tex_w      = w;
    cfg_idx_i  <= REG_TEX_HEIGHT;
    cfg_data_i <= h;
    @(posedge clk_i);
    tex_h      = h;
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    n_sizes++;
  endtask

  // result side: random pop stalls, compare each popped texel with the oldest pending one
  initial begin : pop_drive
    int stall;
    stall = 0;
    pop   <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        pop <= 1'b0;
      end else if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        pop   <= 1'b0;
        stall = $urandom_range(0, 12);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : result_check
    bit   take;
    rgb_t got, want;
    forever begin
      @(negedge clk_i);
      take = rst_ni && pop && !empty;
      got  = {red_o, green_o, blue_o};
      @(posedge clk_i);
      if (take) begin
        if (texel_due_q.size() == 0) begin
          report_mismatch($sformatf("result %06h with no sample pending", got));
        end else begin
          want = texel_due_q.pop_front();
          n_results++;
          if (got.r !== want.r)
            report_mismatch($sformatf("red %02h, expected %02h", got.r, want.r));
          if (got.g !== want.g)
            report_mismatch($sformatf("green %02h, expected %02h", got.g, want.g));
          if (got.b !== want.b)
            report_mismatch($sformatf("blue %02h, expected %02h", got.b, want.b));
        end
      end
    end
  end

  // sizes are zero out of reset; a zero width or height gives cyan
  task automatic test_no_texture();
    sample_at(32'h0000_0000, 32'h0000_0000);
    sample_at(32'h7FFF_FFFF, 32'h8000_0000);
    set_texture_size(9'd0, 9'd511);
    sample_at(32'hFFFF_FFFF, 32'h0001_8000);
    set_texture_size(9'd511, 9'd0);
    sample_at(32'h8000_0000, 32'hFFFF_FFFF);
  endtask

  task automatic test_coordinate_extremes();
    send_request(MODE_LOAD, 16'h0000, rgb_t'(24'h00_00_00), 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(MODE_LOAD, 16'hFFFF, rgb_t'(24'hFF_FF_FF), 32'hFFFF_FFFF, 32'h0000_0000);
    set_texture_size(9'd1, 9'd1);
    sample_at(32'h0000_0000, 32'h0000_0000);
    sample_at(32'hFFFF_FFFF, 32'h8000_0000);
    set_texture_size(9'd256, 9'd256);
    sample_at(32'h0000_FFFF, 32'h0000_0000);
    sample_at(32'h8000_0000, 32'h7FFF_FFFF);
    sample_at(32'h0001_8000, 32'hFFFF_0001);
    // 511 x 511 makes row*width+col run past the RAM and wrap
    set_texture_size(9'd511, 9'd511);
    sample_at(32'hFFFF_FFFF, 32'h0000_0000);
    sample_at(32'h7FFF_8000, 32'hFFFF_FFFF);
  endtask

  task automatic random_item();
    int          pick;
    logic [31:0] u, v;
    pick = $urandom_range(0, 99);
    u    = rand_coord();
    v    = rand_coord();
    if (pick < 30)
      send_request(MODE_LOAD, ADDR_W'($urandom()), rand_rgb(), u, v);
    else if (pick < 45 && tex_w != 0 && tex_h != 0)
      // rewrite a texel that samples are likely to hit
      send_request(MODE_LOAD, texel_addr(u, v), rand_rgb(), $urandom(), $urandom());
    else
      sample_at(u, v);
  endtask

  task automatic test_random_traffic();
    logic [DIM_W-1:0] w, h;
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin w = 9'd1;   h = 9'd1;   end
        1: begin w = 9'd256; h = 9'd256; end
        2: begin w = 9'd511; h = 9'd511; end
        3: begin w = 9'd0;   h = DIM_W'($urandom_range(1, 511)); end
        4: begin w = DIM_W'($urandom_range(1, 511)); h = 9'd0; end
        5: begin w = 9'd1;   h = 9'd511; end
        6: begin w = 9'd511; h = 9'd1;   end
        default: begin
          if ($urandom_range(0, 1)) begin
            w = DIM_W'($urandom_range(2, 16));
            h = DIM_W'($urandom_range(2, 16));
          end else begin
            w = DIM_W'($urandom_range(1, 511));
            h = DIM_W'($urandom_range(1, 511));
          end
        end
      endcase
      set_texture_size(w, h);
      idle_on = (p < N_PHASES - 2);
      repeat (ITEMS_PER_PHASE) random_item();
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_TEX_WIDTH;
    cfg_data_i    <= '0;
    push          <= 1'b0;
    mode_i        <= MODE_LOAD;
    texel_index_i <= '0;
    load_red_i    <= '0;
    load_green_i  <= '0;
    load_blue_i   <= '0;
    u_coord_i     <= '0;
    v_coord_i     <= '0;
    tex_w         = '0;
    tex_h         = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_no_texture();
    test_coordinate_extremes();
    test_random_traffic();
    wait_idle();

    $display("Ran %0d texel loads and %0d samples (%0d with no texture) over %0d sizes.",
             n_loads, n_samples, n_cyan, n_sizes);
    $display("Checked %0d results, %0d mismatches.", n_results, n_errors);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
